// File: hw/rtl/dp2p_pkg.sv
package dp2p_pkg;

    // Fixed sizes of the table, the frame, the queue and the reciprocals
    localparam int TRIG_N      = 1024;
    localparam int PHASE_W     = 10;
    localparam int MAX_WIDTH   = 4096;
    localparam int MAX_HEIGHT  = 4096;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QLVL_W      = 3;
    localparam int RCP_W       = 24;
    localparam int RCP_SHIFT   = 32;

    // Register indexes
    localparam logic [7:0] REG_FRAME_WIDTH  = 8'd0;
    localparam logic [7:0] REG_FRAME_HEIGHT = 8'd1;
    localparam logic [7:0] REG_FOV_H        = 8'd2;
    localparam logic [7:0] REG_FOV_V        = 8'd3;

    // Reciprocals floor(2^32/den) for the reset frame: 360*1280 and 720*720
    localparam logic [RCP_W-1:0] RCP_Y_RESET = 24'd9320;
    localparam logic [RCP_W-1:0] RCP_P_RESET = 24'd8285;

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned FACT_DIV [1:6] = '{6, 20, 42, 72, 110, 156};

    typedef enum logic [1:0] {
        RCP_IDLE,
        RCP_YAW,
        RCP_PITCH
    } rcp_state_t;

    // One queued pixel: rounding numerators, depth and gray
    typedef struct packed {
        logic [30:0] num_y;
        logic        neg_p;
        logic [30:0] mag_p;
        logic [15:0] depth;
        logic [7:0]  gray;
    } work_t;

    typedef struct packed {
        logic              empty;
        logic              full;
        logic [QLVL_W-1:0] level;
    } queue_stat_t;

    typedef logic signed [15:0] trig_t;
    typedef trig_t trig_tab_t [TRIG_N];

    // sin(pi/2 * r/TRIG_N) in Q1.15, Taylor series in Q2.30
    function automatic logic [15:0] quarter_sine(longint unsigned r);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        x    = HALF_PI_Q30 * r / TRIG_N;
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        for (int k = 1; k <= 6; k++)
        begin
            term = (term * x2) >> 30;
            term = term / FACT_DIV[k];
            if (k % 2 == 1)
            begin
                sum = sum - longint'(term);
            end
            else
            begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0)
        begin
            sum = 0;
        end
        sum = (sum + 16384) >>> 15;
        if (sum > 32767)
        begin
            sum = 32767;
        end
        return sum[15:0];
    endfunction

    // Sine of u/(4*TRIG_N) of a turn
    function automatic logic [15:0] turn_sine(longint unsigned u);
        longint unsigned uu;
        longint unsigned q;
        longint unsigned r;
        logic [15:0]     s;
        uu = u % (4 * TRIG_N);
        q  = uu / TRIG_N;
        r  = uu % TRIG_N;
        if (q[0])
        begin
            r = TRIG_N - r;
        end
        s = quarter_sine(r);
        return q[1] ? (16'd0 - s) : s;
    endfunction

    function automatic trig_tab_t build_sin();
        trig_tab_t t;
        for (int i = 0; i < TRIG_N; i++)
        begin
            t[i] = trig_t'(turn_sine(longint'(4 * i)));
        end
        return t;
    endfunction

    function automatic trig_tab_t build_cos();
        trig_tab_t t;
        for (int i = 0; i < TRIG_N; i++)
        begin
            t[i] = trig_t'(turn_sine(longint'(4 * i + TRIG_N)));
        end
        return t;
    endfunction

endpackage

// File: hw/rtl/dp2p_if.sv
// Pixel request channel
interface dp2p_pixel_if;
    logic        valid;
    logic        ready;
    logic [11:0] column;
    logic [11:0] row;
    logic [15:0] depth_mm;
    logic [7:0]  gray;
    modport source (output valid, column, row, depth_mm, gray, input ready);
    modport sink (input valid, column, row, depth_mm, gray, output ready);
endinterface

// Point result channel
interface dp2p_point_if;
    logic               valid;
    logic               ready;
    logic signed [16:0] point_x;
    logic signed [16:0] point_y;
    logic signed [16:0] point_z;
    logic [7:0]         point_gray;
    modport source (output valid, point_x, point_y, point_z, point_gray, input ready);
    modport sink (input valid, point_x, point_y, point_z, point_gray, output ready);
endinterface

// Register write channel
interface dp2p_cfg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  index;
    logic [15:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// File: hw/rtl/dp2p_recip.sv
// Restoring divider: floor(2^32/den) for yaw then pitch, one bit per cycle
module dp2p_recip (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [20:0]               den_y,
    input  logic [21:0]               den_p,
    output logic                      busy,
    output logic [dp2p_pkg::RCP_W-1:0] recip_y,
    output logic [dp2p_pkg::RCP_W-1:0] recip_p
);
    import dp2p_pkg::*;

    rcp_state_t       state_reg, state_next;
    logic [22:0]      rem_reg, rem_next;
    logic [21:0]      den_reg, den_next;
    logic [RCP_W-1:0] quo_reg, quo_next;
    logic [5:0]       cnt_reg, cnt_next;
    logic [RCP_W-1:0] ry_reg, ry_next;
    logic [RCP_W-1:0] rp_reg, rp_next;
    logic [22:0]      trial;
    logic             qbit;
    logic [22:0]      rem_step;
    logic [RCP_W-1:0] quo_step;

    // State and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= RCP_IDLE;
            ry_reg    <= RCP_Y_RESET;
            rp_reg    <= RCP_P_RESET;
        end
        else
        begin
            state_reg <= state_next;
            ry_reg    <= ry_next;
            rp_reg    <= rp_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
        cnt_reg <= cnt_next;
    end

    // One quotient bit: the dividend is a one followed by 32 zeros
    always_comb
    begin
        trial    = {rem_reg[21:0], (cnt_reg == 6'd0)};
        qbit     = (trial >= {1'b0, den_reg});
        rem_step = qbit ? (trial - {1'b0, den_reg}) : trial;
        quo_step = {quo_reg[RCP_W-2:0], qbit};
    end

    // Next state and outputs
    always_comb
    begin
        state_next = state_reg;
        rem_next   = rem_reg;
        den_next   = den_reg;
        quo_next   = quo_reg;
        cnt_next   = cnt_reg;
        ry_next    = ry_reg;
        rp_next    = rp_reg;
        if (start)
        begin
            state_next = RCP_YAW;
            rem_next   = '0;
            den_next   = {1'b0, den_y};
            quo_next   = '0;
            cnt_next   = '0;
        end
        else
        begin
            case (state_reg)
                RCP_IDLE:
                begin
                    state_next = RCP_IDLE;
                end
                RCP_YAW:
                begin
                    rem_next = rem_step;
                    quo_next = quo_step;
                    cnt_next = cnt_reg + 6'd1;
                    if (cnt_reg == 6'(RCP_SHIFT))
                    begin
                        ry_next    = quo_step;
                        state_next = RCP_PITCH;
                        rem_next   = '0;
                        den_next   = den_p;
                        quo_next   = '0;
                        cnt_next   = '0;
                    end
                end
                RCP_PITCH:
                begin
                    rem_next = rem_step;
                    quo_next = quo_step;
                    cnt_next = cnt_reg + 6'd1;
                    if (cnt_reg == 6'(RCP_SHIFT))
                    begin
                        rp_next    = quo_step;
                        state_next = RCP_IDLE;
                    end
                end
                default:
                begin
                    state_next = RCP_IDLE;
                end
            endcase
        end
    end

    assign busy    = (state_reg != RCP_IDLE);
    assign recip_y = ry_reg;
    assign recip_p = rp_reg;

endmodule

// File: hw/rtl/dp2p_front.sv
// Accepts pixels, drops zero depth, forms the angle numerators
module dp2p_front (
    dp2p_pixel_if.sink          pixel,
    input  logic                stall,
    input  logic [7:0]          fov_h,
    input  logic [7:0]          fov_v,
    input  logic [12:0]         height,
    output logic                push,
    output dp2p_pkg::work_t     item
);
    import dp2p_pkg::*;

    logic signed [14:0] diff;
    logic [13:0]        diff_mag;
    logic [20:0]        prod_y;
    logic [21:0]        prod_p;

    assign pixel.ready = !stall;
    assign push = pixel.valid && pixel.ready && (pixel.depth_mm != 16'd0);

    // Yaw numerator fov_h*column*N, pitch numerator fov_v*(H-2*row)*N
    always_comb
    begin
        diff     = $signed({2'b00, height}) - $signed({2'b00, pixel.row, 1'b0});
        diff_mag = diff[14] ? 14'(-diff) : diff[13:0];
        prod_y   = 21'(fov_h * pixel.column);
        prod_p   = 22'(fov_v * diff_mag);
        item.num_y = {prod_y[20:0], {PHASE_W{1'b0}}};
        item.neg_p = diff[14];
        item.mag_p = {prod_p[20:0], {PHASE_W{1'b0}}};
        item.depth = pixel.depth_mm;
        item.gray  = pixel.gray;
    end

endmodule

// File: hw/rtl/dp2p_queue.sv
// Small FIFO between front and back
module dp2p_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  dp2p_pkg::work_t        din,
    input  logic                   pop,
    output dp2p_pkg::work_t        dout,
    output dp2p_pkg::queue_stat_t  stat
);
    import dp2p_pkg::*;

    work_t             mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_reg, wr_next;
    logic [QPTR_W-1:0] rd_reg, rd_next;
    logic [QLVL_W-1:0] lvl_reg, lvl_next;

    always_comb
    begin
        wr_next  = push ? wr_reg + 1'b1 : wr_reg;
        rd_next  = pop ? rd_reg + 1'b1 : rd_reg;
        lvl_next = lvl_reg + QLVL_W'(push) - QLVL_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            lvl_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            lvl_reg <= lvl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_reg] <= din;
        end
    end

    assign dout       = mem[rd_reg];
    assign stat.empty = (lvl_reg == '0);
    assign stat.full  = (lvl_reg == QLVL_W'(QUEUE_DEPTH));
    assign stat.level = lvl_reg;

endmodule

// File: hw/rtl/dp2p_back.sv
// Rounding division by reciprocal, table lookup and point products
module dp2p_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  dp2p_pkg::work_t            head,
    input  logic                       empty,
    input  logic [20:0]                den_y,
    input  logic [21:0]                den_p,
    input  logic [dp2p_pkg::RCP_W-1:0] recip_y,
    input  logic [dp2p_pkg::RCP_W-1:0] recip_p,
    output logic                       pop,
    dp2p_point_if.source               point
);
    import dp2p_pkg::*;

    localparam trig_tab_t SIN_TAB = build_sin();
    localparam trig_tab_t COS_TAB = build_cos();

    logic en;
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, vo_reg;

    // Stage payloads
    logic [30:0]        ay1_reg, ap1_reg, ay2_reg, ap2_reg, ay3_reg, ap3_reg;
    logic [22:0]        qy2_reg, qp2_reg, qy3_reg, qp3_reg;
    logic [30:0]        my3_reg, mp3_reg;
    logic               n1_reg, n2_reg, n3_reg;
    logic [PHASE_W-1:0] phy4_reg, php4_reg;
    trig_t              sy5_reg, cy5_reg, sp5_reg, cp5_reg;
    logic signed [31:0] xs6_reg, ys6_reg;
    logic signed [16:0] z6_reg;
    logic [15:0]        d1_reg, d2_reg, d3_reg, d4_reg, d5_reg, d6_reg;
    logic [7:0]         g1_reg, g2_reg, g3_reg, g4_reg, g5_reg, g6_reg;
    logic signed [16:0] xo_reg, yo_reg, zo_reg;
    logic [7:0]         go_reg;

    logic [54:0]        py_full, pp_full;
    logic [43:0]        my_full;
    logic [44:0]        mp_full;
    logic [30:0]        ry, rp;
    logic [PHASE_W-1:0] qy, qp;
    logic signed [32:0] zp;
    logic signed [32:0] zr;
    logic signed [48:0] xp, yp, xr, yr;

    assign en  = !vo_reg || point.ready;
    assign pop = en && !empty;

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= !empty;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            vo_reg <= v6_reg;
        end
    end

    // Combinational pieces between stages
    always_comb
    begin
        py_full = 55'(ay1_reg * recip_y);
        pp_full = 55'(ap1_reg * recip_p);
        my_full = 44'(qy2_reg * den_y);
        mp_full = 45'(qp2_reg * den_p);
        ry      = ay3_reg - my3_reg;
        rp      = ap3_reg - mp3_reg;
        qy      = qy3_reg[PHASE_W-1:0] + PHASE_W'(ry >= 31'(den_y));
        qp      = qp3_reg[PHASE_W-1:0] + PHASE_W'(rp >= 31'(den_p));
        zp      = 33'(sp5_reg * $signed({1'b0, d5_reg}));
        zr      = zp + (zp[32] ? 33'sd16383 : 33'sd16384);
        xp      = 49'(xs6_reg * $signed({1'b0, d6_reg}));
        yp      = 49'(ys6_reg * $signed({1'b0, d6_reg}));
        xr      = xp + (xp[48] ? 49'sh1FFFFFFF : 49'sh20000000);
        yr      = yp + (yp[48] ? 49'sh1FFFFFFF : 49'sh20000000);
    end

    // Pipeline
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // add half the divisor for rounding
            ay1_reg <= head.num_y + 31'(den_y >> 1);
            ap1_reg <= head.mag_p + 31'(den_p >> 1);
            n1_reg  <= head.neg_p;
            d1_reg  <= head.depth;
            g1_reg  <= head.gray;
            // quotient estimate, at most one short
            qy2_reg <= py_full[54:32];
            qp2_reg <= pp_full[54:32];
            ay2_reg <= ay1_reg;
            ap2_reg <= ap1_reg;
            n2_reg  <= n1_reg;
            d2_reg  <= d1_reg;
            g2_reg  <= g1_reg;
            // back-multiply
            my3_reg <= my_full[30:0];
            mp3_reg <= mp_full[30:0];
            qy3_reg <= qy2_reg;
            qp3_reg <= qp2_reg;
            ay3_reg <= ay2_reg;
            ap3_reg <= ap2_reg;
            n3_reg  <= n2_reg;
            d3_reg  <= d2_reg;
            g3_reg  <= g2_reg;
            // correct and wrap onto the turn
            phy4_reg <= qy;
            php4_reg <= n3_reg ? (PHASE_W'(0) - qp) : qp;
            d4_reg   <= d3_reg;
            g4_reg   <= g3_reg;
            // table reads
            sy5_reg <= SIN_TAB[phy4_reg];
            cy5_reg <= COS_TAB[phy4_reg];
            sp5_reg <= SIN_TAB[php4_reg];
            cp5_reg <= COS_TAB[php4_reg];
            d5_reg  <= d4_reg;
            g5_reg  <= g4_reg;
            // trig products, z rounded
            xs6_reg <= 32'(sy5_reg * cp5_reg);
            ys6_reg <= 32'(cy5_reg * cp5_reg);
            z6_reg  <= zr[31:15];
            d6_reg  <= d5_reg;
            g6_reg  <= g5_reg;
            // depth products, rounded
            xo_reg <= xr[46:30];
            yo_reg <= yr[46:30];
            zo_reg <= z6_reg;
            go_reg <= g6_reg;
        end
    end

    assign point.valid      = vo_reg;
    assign point.point_x    = xo_reg;
    assign point.point_y    = yo_reg;
    assign point.point_z    = zo_reg;
    assign point.point_gray = go_reg;

endmodule

// File: hw/rtl/depth_pixel_to_point_core.sv
// Channel | Dir | Handshake   | Payload
// pixel   | in  | valid/ready | column, row, depth_mm, gray
// point   | out | valid/ready | point_x, point_y, point_z, point_gray
// cfg     | in  | valid/ready | index, data
//
// One pixel per cycle while the queue has room, no reciprocal update is
// pending or running and the output is not stalled. Zero-depth pixels are
// dropped. A register write starts a reciprocal computation (one bit per
// cycle, yaw then pitch); pixel.ready is low until the computation ends.
// Reset (rst_n, async low) restores the default frame and empties the queue.
// Output stalls freeze the back pipeline; the 4-entry queue absorbs input.
module depth_pixel_to_point_core (
    input  logic          clk,
    input  logic          rst_n,
    dp2p_pixel_if.sink    pixel,
    dp2p_point_if.source  point,
    dp2p_cfg_if.sink      cfg
);
    import dp2p_pkg::*;

    logic [12:0]      width_reg, height_reg;
    logic [7:0]       fov_h_reg, fov_v_reg;
    logic             start_reg;
    logic [12:0]      w_eff, h_eff;
    logic [20:0]      den_y;
    logic [21:0]      den_p;
    logic             busy;
    logic [RCP_W-1:0] recip_y, recip_p;
    logic             push, pop;
    work_t            item, head;
    queue_stat_t      stat;
    logic             cfg_wr;

    assign cfg.ready = 1'b1;
    assign cfg_wr    = cfg.valid && cfg.ready;

    // Registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 13'd1280;
            height_reg <= 13'd720;
            fov_h_reg  <= 8'd122;
            fov_v_reg  <= 8'd76;
            start_reg  <= 1'b0;
        end
        else
        begin
            start_reg <= cfg_wr;
            if (cfg_wr)
            begin
                case (cfg.index)
                    REG_FRAME_WIDTH:  width_reg  <= cfg.data[12:0];
                    REG_FRAME_HEIGHT: height_reg <= cfg.data[12:0];
                    REG_FOV_H:        fov_h_reg  <= cfg.data[7:0];
                    REG_FOV_V:        fov_v_reg  <= cfg.data[7:0];
                    default:          ;
                endcase
            end
        end
    end

    // Clamped frame size and rounding divisors
    always_comb
    begin
        w_eff = (width_reg == 13'd0) ? 13'd1 :
                (width_reg > 13'(MAX_WIDTH)) ? 13'(MAX_WIDTH) : width_reg;
        h_eff = (height_reg == 13'd0) ? 13'd1 :
                (height_reg > 13'(MAX_HEIGHT)) ? 13'(MAX_HEIGHT) : height_reg;
        den_y = 21'(w_eff * 9'd360);
        den_p = 22'(h_eff * 10'd720);
    end

    dp2p_recip u_recip (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start_reg),
        .den_y   (den_y),
        .den_p   (den_p),
        .busy    (busy),
        .recip_y (recip_y),
        .recip_p (recip_p)
    );

    dp2p_front u_front (
        .pixel  (pixel),
        .stall  (stat.full || busy || start_reg),
        .fov_h  (fov_h_reg),
        .fov_v  (fov_v_reg),
        .height (h_eff),
        .push   (push),
        .item   (item)
    );

    dp2p_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (item),
        .pop   (pop),
        .dout  (head),
        .stat  (stat)
    );

    dp2p_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .head    (head),
        .empty   (stat.empty),
        .den_y   (den_y),
        .den_p   (den_p),
        .recip_y (recip_y),
        .recip_p (recip_p),
        .pop     (pop),
        .point   (point)
    );

    // No pixel taken while reciprocals are being recomputed
    a_busy_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !pixel.ready)
        else $error("pixel accepted during reciprocal update");

    // Queue never overfills
    a_level: assert property (@(posedge clk) disable iff (!rst_n)
        stat.level <= QLVL_W'(QUEUE_DEPTH))
        else $error("queue overflow");

    // A dropped pixel leaves the queue level alone when nothing is popped
    a_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (pixel.valid && pixel.ready && (pixel.depth_mm == 16'd0) && !pop)
        |=> (stat.level == $past(stat.level)))
        else $error("zero-depth pixel entered queue");

endmodule
